/* rtl/wgm_pkg.sv */
// Shared types and constants for the wildcard glob matcher.
// Used by wgm_cell and wildcard_glob_matcher_unit; no dependencies.
`timescale 1ns / 1ps

package wgm_pkg;

  localparam int MAX_PATTERN_DEF = 16;

  localparam logic [7:0] STAR_CHAR     = 8'd42;
  localparam logic [7:0] QUESTION_CHAR = 8'd63;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_VALUE  = 2'd1,
    ACT_END    = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic overflowed;
  } out_item_t;

  // Broadcast control from the top level to every cell, valid for one cycle.
  typedef struct packed {
    logic       append;
    logic       clear;
    logic       consume;
    logic       restart;
    logic [7:0] ch;
  } cell_ctl_t;

endpackage

/* rtl/wgm_cell.sv */
// One pattern cell: holds one pattern byte, its fill bit and the active bit
// of its pattern position. Depends on wgm_pkg.
`timescale 1ns / 1ps

module wgm_cell import wgm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      seed_i,        // active bit of this position after restart
  input  logic      prev_valid_i,  // previous cell holds a byte
  input  logic      carry_i,       // star closure from previous cell
  input  logic      adv_i,         // previous cell matched the value byte
  output logic      valid_o,
  output logic      carry_o,
  output logic      adv_o,
  output logic      end_hit_o
);

  logic [7:0] byte_r;
  logic       vld_r, vld_nxt;
  logic       raw_r, raw_nxt;
  logic       act;
  logic       hit;
  logic       is_star;
  logic       load;

  assign act     = raw_r | carry_i;
  assign is_star = (byte_r == STAR_CHAR);
  assign hit     = act & vld_r;

  assign carry_o   = hit & is_star;
  assign adv_o     = hit & ~is_star & ((byte_r == QUESTION_CHAR) | (byte_r == ctl.ch));
  // this position is the end of the pattern when it is the first empty cell
  assign end_hit_o = act & prev_valid_i & ~vld_r;
  assign valid_o   = vld_r;

  assign load = ctl.append & prev_valid_i & ~vld_r;

  always_comb begin
    vld_nxt = vld_r;
    if (ctl.clear) begin
      vld_nxt = 1'b0;
    end else if (load) begin
      vld_nxt = 1'b1;
    end
  end

  always_comb begin
    raw_nxt = raw_r;
    if (ctl.restart) begin
      raw_nxt = seed_i;
    end else if (ctl.consume) begin
      raw_nxt = carry_o | adv_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      raw_r <= seed_i;
    end else begin
      vld_r <= vld_nxt;
      raw_r <= raw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= ctl.ch;
    end
  end

endmodule

/* rtl/wildcard_glob_matcher_unit.sv */
// Wildcard glob matcher top level: a row of wgm_cell instances plus the
// end-of-pattern position, overflow flag and output register. Uses wgm_pkg.
`timescale 1ns / 1ps

// Glob matcher for '*' (any run, possibly empty) and '?' (any one byte).
// Load the pattern with append beats, stream value bytes, then send an
// end-of-value beat; that beat alone produces one result beat in the
// following cycle, carrying matched and overflowed. A new beat is
// taken each cycle while the output register is free or being
// drained. All cells update in parallel per value byte; the critical path
// is the star-closure ripple through the MAX_PATTERN cells. Appends past
// MAX_PATTERN bytes are dropped and set overflowed until the next clear.
// Append, clear and end-of-value all restart matching for a fresh value.
module wildcard_glob_matcher_unit import wgm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cell_ctl_t              ctl;
  logic                   in_fire;
  logic [MAX_PATTERN-1:0] vld_vec;
  logic [MAX_PATTERN-1:0] carry_vec;
  logic [MAX_PATTERN-1:0] adv_vec;
  logic [MAX_PATTERN-1:0] end_vec;
  logic [MAX_PATTERN-1:0] prev_vld_in;
  logic [MAX_PATTERN-1:0] carry_in;
  logic [MAX_PATTERN-1:0] adv_in;

  logic      raw_end_r, raw_end_nxt;
  logic      act_end;
  logic      full;
  logic      matched;
  logic      ovf_r, ovf_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  always_comb begin
    ctl.append  = in_fire & (in_data.action == ACT_APPEND);
    ctl.clear   = in_fire & (in_data.action == ACT_CLEAR);
    ctl.consume = in_fire & (in_data.action == ACT_VALUE);
    ctl.restart = in_fire & (in_data.action != ACT_VALUE);
    ctl.ch      = in_data.character;
  end

  genvar i;
  generate
    for (i = 0; i < MAX_PATTERN; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign prev_vld_in[i] = 1'b1;
        assign carry_in[i]    = 1'b0;
        assign adv_in[i]      = 1'b0;
      end else begin : g_link
        assign prev_vld_in[i] = vld_vec[i-1];
        assign carry_in[i]    = carry_vec[i-1];
        assign adv_in[i]      = adv_vec[i-1];
      end

      wgm_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .seed_i       ((i == 0) ? 1'b1 : 1'b0),
        .prev_valid_i (prev_vld_in[i]),
        .carry_i      (carry_in[i]),
        .adv_i        (adv_in[i]),
        .valid_o      (vld_vec[i]),
        .carry_o      (carry_vec[i]),
        .adv_o        (adv_vec[i]),
        .end_hit_o    (end_vec[i])
      );
    end
  endgenerate

  // last position, reached only when every cell holds a byte
  assign act_end = raw_end_r | carry_vec[MAX_PATTERN-1];
  assign full    = vld_vec[MAX_PATTERN-1];
  assign matched = (|end_vec) | (act_end & full);

  always_comb begin
    raw_end_nxt = raw_end_r;
    if (ctl.restart) begin
      raw_end_nxt = 1'b0;
    end else if (ctl.consume) begin
      raw_end_nxt = adv_vec[MAX_PATTERN-1];
    end
  end

  always_comb begin
    ovf_nxt = ovf_r;
    if (ctl.clear) begin
      ovf_nxt = 1'b0;
    end else if (ctl.append & full) begin
      ovf_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire && in_data.action == ACT_END) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_end_r   <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      raw_end_r   <= raw_end_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.action == ACT_END) begin
      out_data_r.matched    <= matched;
      out_data_r.overflowed <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // cells fill strictly from the front
  a_fill_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_vec >> 1) & ~vld_vec) == '0)
    else $error("pattern cells not filled in order");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> (vld_vec == '0) && !ovf_r)
    else $error("clear left pattern bytes or overflow set");

  a_end_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.action == ACT_END) |=> out_valid)
    else $error("end of value produced no result beat");

  a_ovf_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!ovf_r && !(ctl.append && full)) |=> !ovf_r)
    else $error("overflow set without append to full pattern");
`endif

endmodule
